[design/anbd_pkg.sv]
// shared types and constants for the annex b nal deframer
package anbd_pkg;

    typedef enum logic [1:0] {
        K_PAYLOAD = 2'd0,
        K_HEADER  = 2'd1,
        K_END     = 2'd2,
        K_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE      = 2'd0,
        E_FORBIDDEN = 2'd1,
        E_NOT_ZERO  = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] EPB_BYTE   = 8'h03;
    localparam logic [7:0] NUL_BYTE   = 8'h00;
    localparam logic [1:0] RUN_MAX    = 2'd3;
    localparam logic [1:0] RUN_START  = 2'd2;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [1:0]  ref_idc;
        logic [4:0]  unit_type;
        t_err        err;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  zero_run;
        logic        in_unit;
    } t_state;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] items;
        logic [CNT_W-1:0]          count;
    } t_bundle;

endpackage

[design/annexb_nal_deframer.sv]
// top level of the annex b nal deframer: state, result queue and handshakes
//
// usage
//   input channel: one raw stream byte per transfer on i_data_byte, with
//   i_stream_end high on the last byte of a stream. a transfer happens at a
//   rising edge with i_valid high and o_stall low.
//   output channel: one result per transfer (kind, byte, header fields,
//   error code, last_of_run). a transfer happens with o_valid high and
//   i_stall low. last_of_run marks the final result caused by one byte.
//   latency: results of a byte appear in the cycle after its transfer.
//   throughput: one byte per cycle while each byte causes at most one
//   result and the receiver does not stall; a byte with more results
//   (at most four) holds the input, and the next byte is taken in the
//   cycle its last result leaves. bytes causing no result never hold up input.
//   the per-byte step is one pass of logic between the state registers and
//   the four-entry result register, draining one entry per unstalled cycle.
//   reset (synchronous, active low) returns to start code search with no
//   held zeros, no open unit and an empty result queue.
//   while the receiver stalls, the head result holds and new bytes are
//   stalled while the queue holds any result.
module annexb_nal_deframer
    import anbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_ref_idc,
    output logic [4:0]  o_unit_type,
    output logic [1:0]  o_error_code,
    output logic        o_last_of_run
);

    t_state                    r_state;
    t_state                    n_state;
    t_result [MAX_RESULTS-1:0] r_items;
    t_result [MAX_RESULTS-1:0] n_items;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    t_bundle                   w_bundle;
    t_state                    w_step_next;
    logic                      w_in_xfer;
    logic                      w_out_xfer;

    anbd_step u_step (
        .i_state      (r_state),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_next       (w_step_next),
        .o_bundle     (w_bundle)
    );

    // output side
    assign o_valid    = (r_count != '0);
    assign w_out_xfer = o_valid && !i_stall;

    // room for a new byte once the queue empties in this cycle
    assign o_stall   = !((r_count == '0) || (r_count == CNT_W'(1) && !i_stall));
    assign w_in_xfer = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        n_items = r_items;
        n_count = r_count;
        if (w_out_xfer) begin
            // shift the queue one entry toward the head
            n_items = r_items >> $bits(t_result);
            n_count = r_count - CNT_W'(1);
        end
        if (w_in_xfer) begin
            n_state = w_step_next;
            n_items = w_bundle.items;
            n_count = w_bundle.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= PH_SEARCH;
            r_state.zero_run <= 2'd0;
            r_state.in_unit  <= 1'b0;
            r_count          <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_items <= n_items;
    end

    assign o_kind        = r_items[0].kind;
    assign o_out_byte    = r_items[0].data;
    assign o_ref_idc     = r_items[0].ref_idc;
    assign o_unit_type   = r_items[0].unit_type;
    assign o_error_code  = r_items[0].err;
    assign o_last_of_run = (r_count == CNT_W'(1));

    // queue never holds more than one byte's results
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RESULTS))
        else $error("result queue over capacity");

    // an open unit only exists while payload is being parsed
    a_unit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_unit |-> r_state.phase == PH_PAYLOAD)
        else $error("open unit outside payload phase");

    // error results always carry a reason
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_ERROR |-> o_error_code != E_NONE)
        else $error("error result without error code");

    // stalled results stay put until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_items[0]) && $stable(r_count))
        else $error("stalled result changed");

    // a stream end byte leaves the block back in search with nothing held
    a_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && i_stream_end |=>
            r_state.phase == PH_SEARCH && r_state.zero_run == 2'd0 && !r_state.in_unit)
        else $error("state not cleared after stream end");

endmodule

[design/anbd_step.sv]
// per-byte deframing step: next state and the list of results for one byte
module anbd_step
    import anbd_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output t_state      o_next,
    output t_bundle     o_bundle
);

    function automatic t_result mk(t_kind k, logic [7:0] d, logic [1:0] r,
                                   logic [4:0] t, t_err e);
        t_result x;
        x.kind      = k;
        x.data      = d;
        x.ref_idc   = r;
        x.unit_type = t;
        x.err       = e;
        return x;
    endfunction

    function automatic t_bundle push(t_bundle b, t_result r);
        t_bundle x;
        x = b;
        x.items[b.count[IDX_W-1:0]] = r;
        x.count = b.count + CNT_W'(1);
        return x;
    endfunction

    always_comb begin
        t_state  s;
        t_bundle bd;
        logic [7:0] b;
        s  = i_state;
        bd = '0;
        b  = i_data_byte;
        case (i_state.phase)
            PH_HEADER: begin
                bd = push(bd, mk(K_HEADER, b, b[6:5], b[4:0], E_NONE));
                if (b[7]) begin
                    bd = push(bd, mk(K_ERROR, NUL_BYTE, 2'd0, 5'd0, E_FORBIDDEN));
                end
                s.phase    = PH_PAYLOAD;
                s.in_unit  = 1'b1;
                s.zero_run = 2'd0;
            end
            PH_PAYLOAD: begin
                if (b == NUL_BYTE) begin
                    if (i_state.zero_run != RUN_MAX) begin
                        s.zero_run = i_state.zero_run + 2'd1;
                    end
                end else if (b == START_BYTE && i_state.zero_run >= RUN_START) begin
                    bd = push(bd, mk(K_END, NUL_BYTE, 2'd0, 5'd0, E_NONE));
                    s.in_unit  = 1'b0;
                    s.zero_run = 2'd0;
                    s.phase    = PH_HEADER;
                end else if (i_state.zero_run == RUN_MAX) begin
                    // trailing zeros then junk: close the unit and flag
                    bd = push(bd, mk(K_END, NUL_BYTE, 2'd0, 5'd0, E_NONE));
                    bd = push(bd, mk(K_ERROR, NUL_BYTE, 2'd0, 5'd0, E_NOT_ZERO));
                    s.in_unit  = 1'b0;
                    s.zero_run = 2'd0;
                    s.phase    = PH_SEARCH;
                end else if (b == EPB_BYTE && i_state.zero_run == RUN_START) begin
                    // emulation prevention byte, dropped
                    s.zero_run = 2'd0;
                end else begin
                    // release held zeros, then the byte itself
                    if (i_state.zero_run >= 2'd1) begin
                        bd = push(bd, mk(K_PAYLOAD, NUL_BYTE, 2'd0, 5'd0, E_NONE));
                    end
                    if (i_state.zero_run >= 2'd2) begin
                        bd = push(bd, mk(K_PAYLOAD, NUL_BYTE, 2'd0, 5'd0, E_NONE));
                    end
                    bd = push(bd, mk(K_PAYLOAD, b, 2'd0, 5'd0, E_NONE));
                    s.zero_run = 2'd0;
                end
            end
            default: begin
                s.phase = PH_SEARCH;
                if (b == NUL_BYTE) begin
                    if (i_state.zero_run != RUN_MAX) begin
                        s.zero_run = i_state.zero_run + 2'd1;
                    end
                end else if (b == START_BYTE && i_state.zero_run >= RUN_START) begin
                    s.zero_run = 2'd0;
                    s.phase    = PH_HEADER;
                end else begin
                    bd = push(bd, mk(K_ERROR, NUL_BYTE, 2'd0, 5'd0, E_NOT_ZERO));
                    s.zero_run = 2'd0;
                end
            end
        endcase

        if (i_stream_end) begin
            if (s.in_unit) begin
                bd = push(bd, mk(K_END, NUL_BYTE, 2'd0, 5'd0, E_NONE));
            end
            s.phase    = PH_SEARCH;
            s.zero_run = 2'd0;
            s.in_unit  = 1'b0;
        end

        o_next   = s;
        o_bundle = bd;
    end

endmodule
